// ===== rtl/core/sbl_pkg.sv =====
// Package for the stack blur line engine: types, codes and defaults.
`timescale 1ns / 1ps
package sbl_pkg;

  localparam int MAX_RADIUS_DEF = 31;
  localparam int CFG_W          = 10;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT  = 2'd2;

  localparam logic [4:0] RADIUS_RST = 5'd0;
  localparam logic [9:0] FACTOR_RST = 10'd1;
  localparam logic [4:0] SHIFT_RST  = 5'd0;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       last_in_line;
  } sbl_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       last_out;
  } sbl_out_t;

  typedef struct packed {
    logic clr;
    logic acc_en;
    logic mul_en;
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAPS,
    ST_WAIT,
    ST_MUL,
    ST_EMIT
  } sbl_state_t;

endpackage

// ===== rtl/core/sbl_in_if.sv =====
// Input pixel channel: valid/ready with one pixel word.
`timescale 1ns / 1ps
interface sbl_in_if import sbl_pkg::*; ();
  logic    valid;
  logic    ready;
  sbl_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sbl_out_if.sv =====
// Output pixel channel: valid/ready with one blurred pixel word.
`timescale 1ns / 1ps
interface sbl_out_if import sbl_pkg::*; ();
  logic     valid;
  logic     ready;
  sbl_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/stack_blur_line_rgba_top.sv =====
// Top level of the stack blur line engine for RGBA pixels.
//
//  channel | dir | handshake     | word
//  in_ch   | in  | valid/ready   | red_in green_in blue_in alpha_in last_in_line
//  out_ch  | out | valid/ready   | red_out green_out blue_out alpha_out last_out
//  cfg     | in  | cfg_we        | cfg_idx, cfg_data (radius, factor, shift)
//
// Radius 0: pixels pass through; a new pixel is taken only after the last is loaded.
// Radius r: each result reads its taps one a cycle from the single ring read port
// feeding all four lanes, then goes through WAIT and MUL to EMIT; an input giving
// no result leaves the engine idle.
// Reset is synchronous; the ring is not cleared (only current-line pixels read).
// A full output register stalls the engine; input is taken only when idle.
`timescale 1ns / 1ps
module stack_blur_line_rgba_top import sbl_pkg::*; #(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  sbl_in_if.sink               in_ch,
  sbl_out_if.source            out_ch
);
  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(DEPTH + 1);
  localparam int RMAX  = (MAX_RADIUS < 31) ? MAX_RADIUS : 31;
  localparam int WW    = $clog2(RMAX + 2);
  localparam int ACC_W = $clog2((RMAX + 1) * (RMAX + 1) * 255 + 1);

  logic [4:0] radius;
  logic [9:0] scale_factor;
  logic [4:0] scale_shift;

  sbl_state_t state, state_next;

  logic [AW-1:0] ring_position, wpos, k, c, r_q;
  logic [SW-1:0] pixels_seen, s_q;
  logic          cur_last, flushing, pass_q;
  logic [31:0]   pass_px;
  logic          tap_v;
  logic [WW-1:0] w_q;
  logic          out_valid;
  sbl_out_t      out_data;

  logic          accept, out_free, load;
  logic [AW-1:0] r_cfg;
  logic [SW-1:0] seen_n;
  logic [AW-1:0] c_flush_acc, c_flush_emit;
  logic signed [AW+1:0] t_s;
  logic [AW-1:0] age, raddr, abs_j;
  logic [AW:0]   idx_sum;
  logic [WW-1:0] w;
  logic [31:0]   rdata, wdata;
  logic [7:0]    lane_res [4];
  lane_ctrl_t    lctrl;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= RADIUS_RST;
      scale_factor <= FACTOR_RST;
      scale_shift  <= SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RADIUS: radius <= cfg_data[4:0];
        REG_FACTOR: scale_factor <= cfg_data[9:0];
        REG_SHIFT:  scale_shift <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign r_cfg  = (int'(radius) > MAX_RADIUS) ? AW'(MAX_RADIUS) : AW'(radius);
  assign seen_n = (pixels_seen == SW'(DEPTH)) ? SW'(DEPTH) : pixels_seen + 1'b1;

  assign c_flush_acc  = (AW'(seen_n - 1'b1) < r_cfg - 1'b1) ? AW'(seen_n - 1'b1)
                                                            : r_cfg - 1'b1;
  assign c_flush_emit = (AW'(s_q - 1'b1) < r_q - 1'b1) ? AW'(s_q - 1'b1) : r_q - 1'b1;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign load     = (state == ST_EMIT) && out_free;

  assign in_ch.ready = (state == ST_IDLE);

  // tap address and weight
  assign t_s = $signed({2'b00, c}) + $signed({2'b00, r_q}) - $signed({2'b00, k});

  always_comb begin
    if (t_s < 0) begin
      age = '0;
    end else if (t_s > $signed({2'b00, AW'(s_q - 1'b1)})) begin
      age = AW'(s_q - 1'b1);
    end else begin
      age = t_s[AW-1:0];
    end
  end

  assign idx_sum = (wpos >= age) ? {1'b0, wpos} - {1'b0, age}
                                 : {1'b0, wpos} + (AW+1)'(DEPTH) - {1'b0, age};
  assign raddr   = idx_sum[AW-1:0];
  assign abs_j   = (k < r_q) ? r_q - k : k - r_q;
  assign w       = WW'(r_q + 1'b1 - abs_j);

  // FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (r_cfg == '0) begin
            state_next = ST_EMIT;
          end else if (seen_n >= SW'(r_cfg) + 1'b1 || in_ch.data.last_in_line) begin
            state_next = ST_TAPS;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_TAPS: begin
        if ({1'b0, k} == {r_q, 1'b0}) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: state_next = ST_MUL;
      ST_MUL:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          priority if (pass_q) begin
            state_next = ST_IDLE;
          end else if (!flushing && cur_last) begin
            state_next = ST_TAPS;
          end else if (flushing && c != '0) begin
            state_next = ST_TAPS;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_position <= '0;
      pixels_seen   <= '0;
      tap_v         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      tap_v <= (state == ST_TAPS);
      if (accept) begin
        ring_position <= (ring_position == AW'(DEPTH - 1)) ? '0 : ring_position + 1'b1;
        pixels_seen   <= in_ch.data.last_in_line ? '0 : seen_n;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_q <= w;
    if (accept) begin
      wpos     <= ring_position;
      s_q      <= seen_n;
      r_q      <= r_cfg;
      cur_last <= in_ch.data.last_in_line;
      pass_q   <= (r_cfg == '0);
      pass_px  <= wdata;
      k        <= '0;
      if (seen_n >= SW'(r_cfg) + 1'b1) begin
        c        <= r_cfg;
        flushing <= 1'b0;
      end else begin
        c        <= c_flush_acc;
        flushing <= 1'b1;
      end
    end else if (state == ST_TAPS) begin
      k <= k + 1'b1;
    end else if (load) begin
      k <= '0;
      if (!flushing && cur_last) begin
        flushing <= 1'b1;
        c        <= c_flush_emit;
      end else if (flushing && c != '0) begin
        c <= c - 1'b1;
      end
    end
    if (load) begin
      if (pass_q) begin
        out_data <= '{red_out: pass_px[7:0], green_out: pass_px[15:8],
                      blue_out: pass_px[23:16], alpha_out: pass_px[31:24],
                      last_out: cur_last};
      end else begin
        out_data <= '{red_out: lane_res[0], green_out: lane_res[1],
                      blue_out: lane_res[2], alpha_out: lane_res[3],
                      last_out: flushing && c == '0};
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  assign wdata = {in_ch.data.alpha_in, in_ch.data.blue_in,
                  in_ch.data.green_in, in_ch.data.red_in};

  sbl_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ring (
    .clk  (clk),
    .we   (accept),
    .waddr(ring_position),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign lctrl.clr    = (state == ST_TAPS) && (k == '0);
  assign lctrl.acc_en = tap_v;
  assign lctrl.mul_en = (state == ST_MUL);

  for (genvar g = 0; g < 4; g++) begin : g_lane
    sbl_lane #(.WW(WW), .ACC_W(ACC_W)) u_lane (
      .clk   (clk),
      .ctrl  (lctrl),
      .weight(w_q),
      .px    (rdata[8*g +: 8]),
      .factor(scale_factor),
      .shift (scale_shift),
      .res   (lane_res[g])
    );
  end

`ifndef SYNTHESIS
  a_pass_emit: assert property (@(posedge clk) disable iff (rst)
    accept && r_cfg == '0 |=> state == ST_EMIT)
    else $error("pass-through pixel did not go to emit");
  a_wait_mul: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT |=> state == ST_MUL)
    else $error("wait not followed by multiply");
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    load && !pass_q && flushing && c == '0 |=> out_valid && out_data.last_out)
    else $error("final flushed pixel not marked last");
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_TAPS |-> int'(raddr) < DEPTH)
    else $error("ring read address out of range");
`endif
endmodule

// ===== rtl/core/sbl_ram.sv =====
// Generic single write, single read RAM with registered read.
`timescale 1ns / 1ps
module sbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 63
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/sbl_lane.sv =====
// One channel lane: weighted accumulate, scale multiply, shift and saturate.
`timescale 1ns / 1ps
module sbl_lane import sbl_pkg::*; #(
  parameter int WW    = 6,
  parameter int ACC_W = 18
) (
  input  logic          clk,
  input  lane_ctrl_t    ctrl,
  input  logic [WW-1:0] weight,
  input  logic [7:0]    px,
  input  logic [9:0]    factor,
  input  logic [4:0]    shift,
  output logic [7:0]    res
);
  localparam int PW = ACC_W + 10;

  logic [ACC_W-1:0] acc;
  logic [PW-1:0]    prod;
  logic [WW+7:0]    tap;
  logic [PW-1:0]    shifted;

  assign tap = (WW+8)'(weight) * (WW+8)'(px);

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'(tap);
    end
    if (ctrl.mul_en) begin
      prod <= PW'(acc) * PW'(factor);
    end
  end

  assign shifted = prod >> shift;
  assign res     = (|shifted[PW-1:8]) ? 8'hFF : shifted[7:0];
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the RGBA stack blur line engine.
`timescale 1ns / 1ps
module tb_top;
  import sbl_pkg::*;

  localparam int RING_N    = 2 * MAX_RADIUS_DEF + 1;
  localparam int LIMIT_CYC = 600000;
  localparam int SETTLE    = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_RADIUS;
  logic [CFG_W-1:0] cfg_data = '0;

  sbl_in_if  in_ch ();
  sbl_out_if out_ch ();

  logic    px_vld = 1'b0;
  sbl_in_t px_word = '0;
  logic    res_rdy = 1'b0;
  assign in_ch.valid  = px_vld;
  assign in_ch.data   = px_word;
  assign out_ch.ready = res_rdy;

  stack_blur_line_rgba_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // shadow registers and blur state
  int unsigned blur_radius = RADIUS_RST;
  int unsigned blur_factor = FACTOR_RST;
  int unsigned blur_shift  = SHIFT_RST;
  logic [7:0] line_ring [RING_N][4];
  int unsigned ring_wr = 0;
  int unsigned line_len = 0;

  sbl_in_t  pend_px [$];
  sbl_out_t blurred_q [$];
  int  errors = 0;
  int  cycles = 0;
  bit  idle_en = 1'b1;
  bit  hold_req = 1'b0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  rx_hold = 0;

  function automatic sbl_out_t blur_pixel(int r, int ctr, int known, bit lst);
    int a, idx, j, ch;
    int unsigned w;
    longint unsigned acc [4];
    longint unsigned v;
    logic [7:0] res [4];
    sbl_out_t o;
    for (ch = 0; ch < 4; ch++) acc[ch] = 0;
    for (j = -r; j <= r; j++) begin
      a = ctr - j;
      w = r + 1 - (j < 0 ? -j : j);
      if (a < 0) a = 0;
      if (a > known - 1) a = known - 1;
      idx = (ring_wr + 2 * RING_N - 1 - (a % RING_N)) % RING_N;
      for (ch = 0; ch < 4; ch++) acc[ch] += w * line_ring[idx][ch];
    end
    for (ch = 0; ch < 4; ch++) begin
      v = (acc[ch] * blur_factor) >> blur_shift;
      res[ch] = (v > 255) ? 8'd255 : v[7:0];
    end
    o.red_out = res[0];
    o.green_out = res[1];
    o.blue_out = res[2];
    o.alpha_out = res[3];
    o.last_out = lst;
    return o;
  endfunction

  task automatic blur_accept(sbl_in_t w);
    int r, known, c;
    sbl_out_t o;
    r = (blur_radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : blur_radius;
    line_ring[ring_wr][0] = w.red_in;
    line_ring[ring_wr][1] = w.green_in;
    line_ring[ring_wr][2] = w.blue_in;
    line_ring[ring_wr][3] = w.alpha_in;
    ring_wr = (ring_wr + 1) % RING_N;
    known = (line_len + 1 > RING_N) ? RING_N : line_len + 1;
    if (r == 0) begin
      o.red_out = w.red_in;
      o.green_out = w.green_in;
      o.blue_out = w.blue_in;
      o.alpha_out = w.alpha_in;
      o.last_out = w.last_in_line;
      blurred_q.push_back(o);
    end else begin
      if (known >= r + 1) blurred_q.push_back(blur_pixel(r, r, known, 1'b0));
      if (w.last_in_line) begin
        c = (known - 1 < r - 1) ? known - 1 : r - 1;
        while (c >= 0) begin
          blurred_q.push_back(blur_pixel(r, c, known, c == 0));
          c--;
        end
      end
    end
    line_len = w.last_in_line ? 0 : known;
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      px_vld <= 1'b0;
    end else begin
      if (px_vld && in_ch.ready) blur_accept(px_word);
      if (!px_vld || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          px_vld <= 1'b0;
        end else if (pend_px.size() > 0) begin
          px_word <= pend_px.pop_front();
          px_vld <= 1'b1;
          if (idle_en && $urandom_range(0, 7) == 0) tx_gap <= $urandom_range(1, 11);
        end else begin
          px_vld <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    sbl_out_t e;
    if (rst) begin
      res_rdy <= 1'b0;
    end else begin
      if (out_ch.valid && res_rdy) begin
        if (blurred_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_ch.data);
          errors++;
        end else begin
          e = blurred_q.pop_front();
          if (e.red_out !== out_ch.data.red_out || e.green_out !== out_ch.data.green_out ||
              e.blue_out !== out_ch.data.blue_out || e.alpha_out !== out_ch.data.alpha_out ||
              e.last_out !== out_ch.data.last_out) begin
            $display("%0t: mismatch exp r%h g%h b%h a%h l%b got r%h g%h b%h a%h l%b",
                     $time, e.red_out, e.green_out, e.blue_out, e.alpha_out, e.last_out,
                     out_ch.data.red_out, out_ch.data.green_out, out_ch.data.blue_out,
                     out_ch.data.alpha_out, out_ch.data.last_out);
            errors++;
          end
        end
      end
      if (hold_req && rx_hold == 0) begin
        rx_hold <= 400;
        hold_req <= 1'b0;
        res_rdy <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        res_rdy <= (rx_hold == 1);
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        res_rdy <= 1'b0;
      end else if (idle_en && $urandom_range(0, 6) == 0) begin
        rx_gap <= $urandom_range(0, 10);
        res_rdy <= 1'b0;
      end else begin
        res_rdy <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("** stack_blur_line_rgba_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RADIUS: blur_radius = val & 5'h1f;
      REG_FACTOR: blur_factor = val & 10'h3ff;
      REG_SHIFT:  blur_shift  = val & 5'h1f;
      default: ;
    endcase
  endtask

  task automatic set_blur(int unsigned r, int unsigned f, int unsigned s);
    write_reg(REG_RADIUS, r);
    write_reg(REG_FACTOR, f);
    write_reg(REG_SHIFT, s);
  endtask

  task automatic push_px(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl, logic [7:0] al,
                         bit lst);
    sbl_in_t w;
    w.red_in = rd;
    w.green_in = gr;
    w.blue_in = bl;
    w.alpha_in = al;
    w.last_in_line = lst;
    pend_px.push_back(w);
  endtask

  task automatic push_line(int n, bit close);
    for (int i = 0; i < n; i++)
      push_px($urandom, $urandom, $urandom, $urandom, close && (i == n - 1));
  endtask

  // sampled mid-cycle so the driver's updates at the edge are settled
  task automatic drain();
    do @(negedge clk); while (pend_px.size() > 0 || px_vld || blurred_q.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_blur();
    int unsigned r, s, f;
    r = ($urandom_range(0, 5) == 0) ? 31 : $urandom_range(0, 12);
    if ($urandom_range(0, 4) == 0) begin
      f = $urandom_range(0, 1023);
      s = $urandom_range(0, 31);
    end else begin
      s = $urandom_range(6, 16);
      f = ((1 << s) / ((r + 1) * (r + 1))) + $urandom_range(0, 3);
      if (f > 1023) f = 1023;
    end
    set_blur(r, f, s);
  endtask

  initial begin
    int sent;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // pass-through at reset values
    push_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    push_px(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    push_px(8'h5a, 8'ha5, 8'h0f, 8'hf0, 1'b1);
    push_px(8'hff, 8'h00, 8'hff, 8'h00, 1'b1);
    drain();
    // widest radius on short lines
    set_blur(31, 1, 10);
    push_line(3, 1'b1);
    push_line(1, 1'b1);
    drain();
    // saturation
    set_blur(1, 1023, 0);
    push_px(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    push_px(8'h01, 8'h80, 8'hff, 8'h00, 1'b0);
    push_line(2, 1'b1);
    drain();
    // zero factor, widest shift
    set_blur(2, 0, 31);
    push_line(3, 1'b1);
    drain();
    // radius changed part way along a line
    set_blur(3, 57, 10);
    push_line(5, 1'b0);
    drain();
    write_reg(REG_RADIUS, 1);
    push_line(3, 1'b1);
    drain();

    sent = 0;
    for (int ph = 0; ph < 12; ph++) begin
      if (ph >= 9) idle_en = 1'b0;
      random_blur();
      if (ph == 4) hold_req <= 1'b1;
      while (sent < (ph + 1) * 29) begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 24);
        push_line(n, $urandom_range(0, 9) != 0);
        sent += n;
      end
      if (ph % 3 == 2) push_line(1, 1'b1);
      drain();
    end

    if (errors == 0 && blurred_q.size() == 0) begin
      $display("** stack_blur_line_rgba_top: PASSED **");
    end else begin
      $display("%0t: %0d words still expected", $time, blurred_q.size());
      $display("** stack_blur_line_rgba_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sbl_pkg.sv
rtl/core/sbl_in_if.sv
rtl/core/sbl_out_if.sv
rtl/core/sbl_ram.sv
rtl/core/sbl_lane.sv
rtl/core/stack_blur_line_rgba_top.sv
verif/tb_top.sv
